// ===== sv/modexp_pkg.sv =====
// Shared types and constants of the modular exponentiation unit.
`default_nettype none

package modexp_pkg;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd1;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CHECK   = 9'b000000010,
        ST_REDUCE  = 9'b000000100,
        ST_SCAN    = 9'b000001000,
        ST_STEP    = 9'b000010000,
        ST_SQ_WAIT = 9'b000100000,
        ST_MU_WAIT = 9'b001000000,
        ST_NEXT    = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULT
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_go;
        op_t  op;
        logic acc_from_b;
        logic acc_from_prod;
        logic b_from_prod;
        logic shift_e;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic e_msb;
        logic mul_done;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/modexp_mulmod.sv =====
// Interleaved shift-add modular multiplier, one multiplier bit per cycle.
`default_nettype none

module modexp_mulmod #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     go,
    input  wire logic [OPERAND_WIDTH-1:0] a,
    input  wire logic [OPERAND_WIDTH-1:0] b,
    input  wire logic [OPERAND_WIDTH-1:0] m,
    output logic                          done,
    output logic [OPERAND_WIDTH-1:0]      product
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    logic                     active_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [OPERAND_WIDTH-1:0] acc_reg;
    logic [OPERAND_WIDTH-1:0] a_reg;
    logic [OPERAND_WIDTH-1:0] mpl_reg;

    logic [OPERAND_WIDTH:0]   mod_ext;
    logic [OPERAND_WIDTH:0]   dbl;
    logic [OPERAND_WIDTH-1:0] red1;
    logic [OPERAND_WIDTH:0]   sum2;
    logic [OPERAND_WIDTH-1:0] red2;
    logic [OPERAND_WIDTH-1:0] acc_next;

    // zero modulus stands for 2^OPERAND_WIDTH
    always_comb
    begin
        mod_ext = {(m == '0), m};
        dbl     = {1'b0, acc_reg} + {1'b0, acc_reg};
        red1    = (dbl >= mod_ext) ? OPERAND_WIDTH'(dbl - mod_ext) : dbl[OPERAND_WIDTH-1:0];
        sum2    = {1'b0, red1} + {1'b0, a_reg};
        red2    = (sum2 >= mod_ext) ? OPERAND_WIDTH'(sum2 - mod_ext) : sum2[OPERAND_WIDTH-1:0];
        acc_next = mpl_reg[OPERAND_WIDTH-1] ? red2 : red1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (go)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == '0)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            mpl_reg <= b;
            cnt_reg <= CNT_W'(OPERAND_WIDTH - 1);
        end
        else if (active_reg)
        begin
            acc_reg <= acc_next;
            mpl_reg <= {mpl_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

`ifndef SYNTHESIS
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !active_reg)
        else $error("multiply started while busy");
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(active_reg))
        else $error("multiply done without a run");
`endif

endmodule

`default_nettype wire

// ===== sv/modexp_dp.sv =====
// Datapath: operand registers, exponent shifter and the modular multiplier.
`default_nettype none

module modexp_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire modexp_pkg::cmd_t         cmd,
    input  wire logic [OPERAND_WIDTH-1:0] modulus,
    input  wire logic [OPERAND_WIDTH-1:0] exponent,
    input  wire logic [OPERAND_WIDTH-1:0] base,
    output modexp_pkg::status_t           status,
    output logic [OPERAND_WIDTH-1:0]      power_result
);

    import modexp_pkg::*;

    logic [OPERAND_WIDTH-1:0] acc_reg;
    logic [OPERAND_WIDTH-1:0] b_reg;
    logic [OPERAND_WIDTH-1:0] e_reg;
    logic [OPERAND_WIDTH-1:0] mul_a;
    logic [OPERAND_WIDTH-1:0] mul_b;
    logic [OPERAND_WIDTH-1:0] prod;
    logic                     mul_done;

    always_comb
    begin
        unique case (cmd.op)
            OP_REDUCE:
            begin
                mul_a = OPERAND_WIDTH'(1);
                mul_b = b_reg;
            end
            OP_SQUARE:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            OP_MULT:
            begin
                // take the square straight from the multiplier as it finishes
                mul_a = prod;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = b_reg;
            end
        endcase
    end

    modexp_mulmod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.mul_go),
        .a      (mul_a),
        .b      (mul_b),
        .m      (modulus),
        .done   (mul_done),
        .product(prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= OPERAND_WIDTH'(1);
            b_reg   <= base;
            e_reg   <= exponent;
        end
        else
        begin
            if (cmd.acc_from_b)
                acc_reg <= b_reg;
            else if (cmd.acc_from_prod)
                acc_reg <= prod;
            if (cmd.b_from_prod)
                b_reg <= prod;
            if (cmd.shift_e)
                e_reg <= {e_reg[OPERAND_WIDTH-2:0], 1'b0};
        end
    end

    assign status.exp_zero = (e_reg == '0);
    assign status.e_msb    = e_reg[OPERAND_WIDTH-1];
    assign status.mul_done = mul_done;
    assign power_result    = acc_reg;

endmodule

`default_nettype wire

// ===== sv/modexp_ctrl.sv =====
// Controller: sequences reduction, exponent scan and square-and-multiply steps.
`default_nettype none

module modexp_ctrl #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire modexp_pkg::status_t status,
    output modexp_pkg::cmd_t         cmd,
    output logic                     busy,
    output logic                     done
);

    import modexp_pkg::*;

    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = OP_REDUCE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(OPERAND_WIDTH - 1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.mul_go = 1'b1;
                    cmd.op     = OP_REDUCE;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.mul_done)
                begin
                    cmd.b_from_prod = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.shift_e = 1'b1;
                if (status.e_msb)
                begin
                    cmd.acc_from_b = 1'b1;
                    if (cnt_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_STEP;
                    end
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_STEP:
            begin
                cmd.mul_go = 1'b1;
                cmd.op     = OP_SQUARE;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                cmd.op = OP_SQUARE;
                if (status.mul_done)
                begin
                    cmd.acc_from_prod = 1'b1;
                    if (status.e_msb)
                    begin
                        cmd.mul_go = 1'b1;
                        cmd.op     = OP_MULT;
                        state_next = ST_MU_WAIT;
                    end
                    else
                        state_next = ST_NEXT;
                end
            end
            ST_MU_WAIT:
            begin
                cmd.op = OP_MULT;
                if (status.mul_done)
                begin
                    cmd.acc_from_prod = 1'b1;
                    state_next        = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cmd.shift_e = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

`ifndef SYNTHESIS
    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but controller stayed idle");
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("result strobe not followed by idle");
`endif

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation unit: configuration registers and core.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | start / busy       | base
//   result   | done (strobe)      | power_result
//   config   | cfg_write          | cfg_index, cfg_data
//
// How long one item keeps busy high grows with the position of the top set bit of the
// exponent; the bit-serial modular multiplier takes most of that time. A zero exponent
// goes from the check state straight to the done state, with no multiply. Reset leaves
// modulus 1, exponent 0. The result is shown for one cycle with done; the receiver
// cannot stall it.
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [OPERAND_WIDTH-1:0]              base,
    output logic                                       done,
    output logic [OPERAND_WIDTH-1:0]                   power_result,
    input  wire logic                                  cfg_write,
    input  wire logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [OPERAND_WIDTH-1:0]              cfg_data
);

    import modexp_pkg::*;

    logic [OPERAND_WIDTH-1:0] modulus_reg;
    logic [OPERAND_WIDTH-1:0] exponent_reg;
    cmd_t                     cmd;
    status_t                  status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= OPERAND_WIDTH'(1);
            exponent_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_MODULUS)
                modulus_reg <= cfg_data;
            else if (cfg_index == REG_EXPONENT)
                exponent_reg <= cfg_data;
        end
    end

    modexp_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    modexp_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .modulus     (modulus_reg),
        .exponent    (exponent_reg),
        .base        (base),
        .status      (status),
        .power_result(power_result)
    );

endmodule

`default_nettype wire

// ===== bench/modular_exponentiation_tb.sv =====
// Self-checking testbench of the modular exponentiation unit: directed table, random key phases.
module modular_exponentiation_tb;

    import modexp_pkg::*;

    localparam int W = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;
    localparam int DIRECTED_ROWS = 18;
    localparam int KEY_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 26;

    typedef struct packed {
        logic [W-1:0] modulus;
        logic [W-1:0] exponent;
        logic [W-1:0] base;
        logic         typed;
        logic [W-1:0] power;
    } key_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [W-1:0]               base;
    logic                       done;
    logic [W-1:0]               power_result;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [W-1:0]               cfg_data;

    logic [W-1:0] key_modulus;
    logic [W-1:0] key_exponent;
    logic [W-1:0] awaited_powers[$];
    key_row_t     key_rows [0:DIRECTED_ROWS-1];
    int           mismatches;
    int           bases_sent;
    int           powers_checked;
    int           spare_writes;

    modular_exponentiation #(
        .OPERAND_WIDTH(W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base         (base),
        .done         (done),
        .power_result (power_result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] m);
        logic [2*W-1:0] prod;
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        if (m == '0)
            return prod[W-1:0];
        prod = prod % {{W{1'b0}}, m};
        return prod[W-1:0];
    endfunction

    function automatic logic [W-1:0] mod_pow(logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] reduced;
        int           top;
        if (e == '0)
            return 1;
        reduced = (m == '0) ? b : b % m;
        top = W - 1;
        while (!e[top])
            top--;
        acc = reduced;
        for (int i = top - 1; i >= 0; i--)
        begin
            acc = mul_mod(acc, acc, m);
            if (e[i])
                acc = mul_mod(acc, reduced, m);
        end
        return acc;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_powers.size() == 0)
                report_mismatch("unexpected power_result", power_result, '0);
            else
            begin
                if (power_result !== awaited_powers[0])
                    report_mismatch("power_result", power_result, awaited_powers[0]);
                void'(awaited_powers.pop_front());
                powers_checked++;
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_powers.size() != 0 || busy);
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MODULUS)
            key_modulus = value;
        else if (idx == REG_EXPONENT)
            key_exponent = value;
        else
            spare_writes++;
    endtask

    task automatic load_key(logic [W-1:0] m, logic [W-1:0] e);
        if (m != key_modulus)
            write_register(REG_MODULUS, m);
        if (e != key_exponent)
            write_register(REG_EXPONENT, e);
    endtask

    task automatic send_base(logic [W-1:0] b, logic typed, logic [W-1:0] power);
        @(negedge clk);
        start <= 1'b1;
        base  <= b;
        do
            @(posedge clk);
        while (busy);
        awaited_powers.push_back(typed ? power : mod_pow(b, key_exponent, key_modulus));
        bases_sent++;
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    function automatic int draw_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    initial
    begin
        #50_000_000;
        $display("FAIL modular_exponentiation");
        $finish;
    end

    initial
    begin
        logic [W-1:0] m;
        logic [W-1:0] e;
        logic [W-1:0] b;
        logic [63:0]  mask;
        int           k;
        bit           quiet;

        rst_n = 1'b0;
        start = 1'b0;
        base = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        key_modulus = 1;
        key_exponent = '0;
        mismatches = 0;
        bases_sent = 0;
        powers_checked = 0;
        spare_writes = 0;

        key_rows = '{
            '{32'd1,          32'd0,          32'hFFFF_FFFF, 1'b1, 32'd1},
            '{32'd1,          32'd5,          32'd123,       1'b1, 32'd0},
            '{32'd1,          32'd0,          32'd0,         1'b1, 32'd1},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd0},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,         1'b1, 32'd0},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,         1'b1, 32'd1},
            '{32'hFFFF_FFFF,  32'd0,          32'h1234_5678, 1'b1, 32'd1},
            '{32'd0,          32'd2,          32'hFFFF_FFFF, 1'b1, 32'd1},
            '{32'd0,          32'hFFFF_FFFF,  32'd3,         1'b0, 32'd0},
            '{32'd0,          32'd1,          32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF},
            '{32'hFFFF_FFFB,  32'd65537,      32'h1234_5678, 1'b0, 32'd0},
            '{32'hFFFF_FFFB,  32'hFFFF_FFFA,  32'd2,         1'b1, 32'd1},
            '{32'h8000_0000,  32'd31,         32'd2,         1'b1, 32'd0},
            '{32'd7,          32'd1,          32'hFFFF_FFFF, 1'b0, 32'd0},
            '{32'd3233,       32'd17,         32'd65,        1'b1, 32'd2790},
            '{32'd3233,       32'd2753,       32'd2790,      1'b1, 32'd65},
            '{32'h0001_0001,  32'h5555_5555,  32'hAAAA_AAAA, 1'b0, 32'd0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            load_key(key_rows[r].modulus, key_rows[r].exponent);
            send_base(key_rows[r].base, key_rows[r].typed, key_rows[r].power);
            hold_off(draw_gap(1'b0));
            if (r == 0)
            begin
                write_register(REG_SPARE_LO, '1);
                write_register(REG_SPARE_HI, 32'h0000_0002);
            end
        end

        for (int ph = 0; ph < KEY_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0: m = $urandom_range(1, 255);
                1: m = 32'd1 << $urandom_range(0, W - 1);
                2: m = '1;
                3: m = '0;
                4: m = 32'd1;
                default: m = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: e = '0;
                1: e = 32'd65537;
                2: e = $urandom | 32'h8000_0000;
                3: e = $urandom;
                default:
                begin
                    k = $urandom_range(1, 12);
                    mask = (64'd1 << k) - 1;
                    e = ($urandom & mask[W-1:0]) | (32'd1 << (k - 1));
                end
            endcase
            if ($urandom_range(0, 9) < 3)
                write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            load_key(m, e);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 9))
                    0: b = '0;
                    1: b = '1;
                    2: b = key_modulus - 1;
                    3: b = $urandom_range(0, 15);
                    default: b = $urandom;
                endcase
                send_base(b, 1'b0, '0);
                hold_off(draw_gap(quiet));
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Sent %0d bases over %0d random keys plus a directed table; %0d results checked.",
                 bases_sent, KEY_PHASES, powers_checked);
        $display("Keys covered zero, unit, power-of-two and full-range moduli; %0d ignored writes.",
                 spare_writes);
        if (mismatches == 0 && awaited_powers.size() == 0)
            $display("PASS modular_exponentiation");
        else
            $display("FAIL modular_exponentiation");
        $finish;
    end

endmodule
